FILE: rtl/core/bvg_pkg.sv
// shared types, constants and the lipo curve of the battery voltage gauge
package bvg_pkg;

	localparam int SAMPLE_W = 12;
	localparam int MV_W     = 16;
	localparam int PCT_W    = 7;
	localparam int GAIN_W   = 16;
	localparam int GAIN_FRAC = 12;

	// configuration register indexes
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_DIVIDER_GAIN   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LOW_VOLTAGE_MV = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LOW_PERCENT    = 2'd2;
	localparam int CFG_DATA_W = 16;

	localparam logic [GAIN_W-1:0] GAIN_RESET        = 16'd12288;
	localparam logic [MV_W-1:0]   LOW_VOLTAGE_RESET = 16'd3300;
	localparam logic [PCT_W-1:0]  LOW_PERCENT_RESET = 7'd10;

	localparam logic [MV_W-1:0]  FULL_MV     = 16'd4200;
	localparam logic [MV_W-1:0]  EMPTY_MV    = 16'd3000;
	localparam logic [PCT_W-1:0] PCT_FULL    = 7'd100;
	localparam logic [PCT_W-1:0] PCT_EMPTY   = 7'd0;

	// floor(p / 100) for p < 2000 as (p * 1311) >> 17
	localparam int PROD_W      = 13;
	localparam int RECIP_W     = 24;
	localparam logic [RECIP_W-1:0] RECIP_100 = 24'd1311;
	localparam int RECIP_SHIFT = 17;

	localparam int DIFF_W     = 8;
	localparam int SPAN_W     = 5;
	localparam int SEGMENTS   = 11;

	typedef struct packed {
		logic [MV_W-1:0]   lo;
		logic [PCT_W-1:0]  base;
		logic [SPAN_W-1:0] span;
		logic              wide;   // segment width 200 instead of 100
	} seg_t;

	localparam seg_t LIPO_CURVE [SEGMENTS] = '{
		'{16'd4100, 7'd95, 5'd5,  1'b0},
		'{16'd4000, 7'd85, 5'd10, 1'b0},
		'{16'd3900, 7'd75, 5'd10, 1'b0},
		'{16'd3800, 7'd60, 5'd15, 1'b0},
		'{16'd3700, 7'd40, 5'd20, 1'b0},
		'{16'd3600, 7'd25, 5'd15, 1'b0},
		'{16'd3500, 7'd15, 5'd10, 1'b0},
		'{16'd3400, 7'd8,  5'd7,  1'b0},
		'{16'd3300, 7'd4,  5'd4,  1'b0},
		'{16'd3200, 7'd1,  5'd3,  1'b0},
		'{16'd3000, 7'd0,  5'd1,  1'b1}
	};

	// first segment whose lower bound is at or below mv
	function automatic seg_t seg_of(input logic [MV_W-1:0] mv);
		seg_t res;
		res = '0;
		for (int i = SEGMENTS - 1; i >= 0; i--) begin
			if (mv >= LIPO_CURVE[i].lo)
				res = LIPO_CURVE[i];
		end
		return res;
	endfunction

endpackage

FILE: rtl/core/bvg_if.sv
// valid/ready channels for samples and gauge results
interface bvg_sample_if;
	logic                          valid;
	logic                          ready;
	logic [bvg_pkg::SAMPLE_W-1:0]  sample_mv;

	modport source (output valid, output sample_mv, input ready);
	modport sink   (input valid, input sample_mv, output ready);
endinterface

interface bvg_result_if;
	logic                       valid;
	logic                       ready;
	logic [bvg_pkg::MV_W-1:0]   average_mv;
	logic [bvg_pkg::PCT_W-1:0]  charge_percent;
	logic                       battery_low;

	modport source (output valid, output average_mv, output charge_percent,
		output battery_low, input ready);
	modport sink   (input valid, input average_mv, input charge_percent,
		input battery_low, output ready);
endinterface

FILE: rtl/core/bvg_ram.sv
// generic single write port ram with registered read
module bvg_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 8
) (
	input  logic                                  clk,
	input  logic                                  wr_en,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                      wr_data,
	input  logic                                  rd_en,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                      rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en)
			mem_q[wr_addr] <= wr_data;
		if (rd_en)
			rd_data <= mem_q[rd_addr];
	end

endmodule

FILE: rtl/core/battery_voltage_gauge.sv
// battery voltage gauge: scaling, ring average, lipo curve and low flag
// flow: a new sample is taken only once the result of the last one has entered the
//   output register; the mean covers the written ring entries, up to SAMPLES, and is
//   formed by the ring read sweep and the one-bit-per-cycle restoring divider
// reset: arst_n clears the sequencer, ring pointer, fill state and output valid,
//   and loads the register reset values; ring contents stay unknown until written
module battery_voltage_gauge #(
	parameter int SAMPLES = 8
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_wr_en,
	input  logic [bvg_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [bvg_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	bvg_sample_if.sink                       sample_ch,
	bvg_result_if.source                     result_ch
);

	localparam int SLOT_W = (SAMPLES > 1) ? $clog2(SAMPLES) : 1;
	localparam int CNT_W  = $clog2(SAMPLES + 1);
	localparam int SUM_W  = bvg_pkg::MV_W + $clog2(SAMPLES);
	localparam int STEP_W = $clog2(SUM_W);
	localparam int MUL_W  = bvg_pkg::SAMPLE_W + bvg_pkg::GAIN_W;

	// sequencer states
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_MUL  = 3'd1;
	localparam logic [2:0] S_WR   = 3'd2;
	localparam logic [2:0] S_SUM  = 3'd3;
	localparam logic [2:0] S_DIV  = 3'd4;
	localparam logic [2:0] S_SEG  = 3'd5;
	localparam logic [2:0] S_PCT  = 3'd6;

	logic [2:0] state_q;

	// configuration registers
	logic [bvg_pkg::GAIN_W-1:0] gain_q;
	logic [bvg_pkg::MV_W-1:0]   low_mv_q;
	logic [bvg_pkg::PCT_W-1:0]  low_pct_q;

	// ring bookkeeping
	logic [SLOT_W-1:0] slot_q;
	logic              full_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [CNT_W-1:0]  iss_q;
	logic              rd_vld_q;

	// datapath registers
	logic [bvg_pkg::SAMPLE_W-1:0] samp_q;
	logic [bvg_pkg::MV_W-1:0]     scaled_q;
	logic [SUM_W-1:0]             acc_q;
	logic [SUM_W-1:0]             quo_q;
	logic [CNT_W-1:0]             rem_q;
	logic [STEP_W-1:0]            step_q;
	logic [bvg_pkg::MV_W-1:0]     avg_q;
	logic [bvg_pkg::PROD_W-1:0]   prod_q;
	logic [bvg_pkg::PCT_W-1:0]    base_q;
	logic                         wide_q;
	logic                         clamp_hi_q;
	logic                         clamp_lo_q;

	// output register
	logic                         out_vld_q;
	logic [bvg_pkg::MV_W-1:0]     out_avg_q;
	logic [bvg_pkg::PCT_W-1:0]    out_pct_q;
	logic                         out_low_q;

	logic                         in_fire;
	logic                         out_free;
	logic [MUL_W-1:0]             mul_full;
	logic                         rd_issue;
	logic [bvg_pkg::MV_W-1:0]     rd_data;
	logic [CNT_W:0]               rem_shift;
	logic                         rem_ge;
	bvg_pkg::seg_t                seg;
	logic [bvg_pkg::DIFF_W-1:0]   seg_diff;
	logic [bvg_pkg::RECIP_W-1:0]  recip_full;
	logic [bvg_pkg::PCT_W-1:0]    q100;
	logic [bvg_pkg::PCT_W-1:0]    seg_q;
	logic [bvg_pkg::PCT_W-1:0]    pct;

	assign sample_ch.ready = (state_q == S_IDLE);
	assign in_fire         = sample_ch.valid && sample_ch.ready;
	assign out_free        = !out_vld_q || result_ch.ready;

	assign result_ch.valid          = out_vld_q;
	assign result_ch.average_mv     = out_avg_q;
	assign result_ch.charge_percent = out_pct_q;
	assign result_ch.battery_low    = out_low_q;

	// scale tap millivolts to battery millivolts, q4.12 gain
	assign mul_full = MUL_W'(samp_q) * MUL_W'(gain_q);

	// ring read sweep: one entry a cycle from slot zero up to the fill count
	assign rd_issue = (state_q == S_SUM) && (iss_q < cnt_q);

	bvg_ram #(
		.WIDTH (bvg_pkg::MV_W),
		.DEPTH (SAMPLES)
	) u_ring (
		.clk     (clk),
		.wr_en   (state_q == S_WR),
		.wr_addr (slot_q),
		.wr_data (scaled_q),
		.rd_en   (rd_issue),
		.rd_addr (iss_q[SLOT_W-1:0]),
		.rd_data (rd_data)
	);

	// restoring divider step, one quotient bit a cycle
	assign rem_shift = {rem_q, quo_q[SUM_W-1]};
	assign rem_ge    = (rem_shift >= (CNT_W + 1)'(cnt_q));

	// curve segment lookup on the finished mean
	assign seg      = bvg_pkg::seg_of(quo_q[bvg_pkg::MV_W-1:0]);
	assign seg_diff = bvg_pkg::DIFF_W'(quo_q[bvg_pkg::MV_W-1:0] - seg.lo);

	// interpolation: divide by segment width through a reciprocal
	assign recip_full = bvg_pkg::RECIP_W'(prod_q) * bvg_pkg::RECIP_100;
	assign q100       = recip_full[bvg_pkg::RECIP_SHIFT +: bvg_pkg::PCT_W];
	assign seg_q      = wide_q ? (q100 >> 1) : q100;

	always_comb begin
		if (clamp_hi_q)
			pct = bvg_pkg::PCT_FULL;
		else if (clamp_lo_q)
			pct = bvg_pkg::PCT_EMPTY;
		else
			pct = base_q + seg_q;
	end

	// configuration writes, index beyond the list is dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q    <= bvg_pkg::GAIN_RESET;
			low_mv_q  <= bvg_pkg::LOW_VOLTAGE_RESET;
			low_pct_q <= bvg_pkg::LOW_PERCENT_RESET;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				bvg_pkg::REG_DIVIDER_GAIN:   gain_q    <= cfg_wdata;
				bvg_pkg::REG_LOW_VOLTAGE_MV: low_mv_q  <= cfg_wdata;
				bvg_pkg::REG_LOW_PERCENT:    low_pct_q <= cfg_wdata[bvg_pkg::PCT_W-1:0];
				default: ;
			endcase
		end
	end

	// sequencer and its control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			slot_q    <= '0;
			full_q    <= 1'b0;
			cnt_q     <= '0;
			iss_q     <= '0;
			rd_vld_q  <= 1'b0;
			step_q    <= '0;
			out_vld_q <= 1'b0;
		end else begin
			// a new result takes the output register, else a taken result leaves it
			if (state_q == S_PCT && out_free)
				out_vld_q <= 1'b1;
			else if (result_ch.ready)
				out_vld_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (in_fire)
						state_q <= S_MUL;
				end
				S_MUL: begin
					state_q <= S_WR;
				end
				S_WR: begin
					// advance the write slot, the ring is full once it wraps
					if (slot_q == SLOT_W'(SAMPLES - 1)) begin
						slot_q <= '0;
						full_q <= 1'b1;
						cnt_q  <= CNT_W'(SAMPLES);
					end else begin
						slot_q <= slot_q + 1'b1;
						cnt_q  <= full_q ? CNT_W'(SAMPLES) : CNT_W'(slot_q) + 1'b1;
					end
					iss_q    <= '0;
					rd_vld_q <= 1'b0;
					state_q  <= S_SUM;
				end
				S_SUM: begin
					if (rd_issue)
						iss_q <= iss_q + 1'b1;
					rd_vld_q <= rd_issue;
					if (!rd_issue && !rd_vld_q) begin
						step_q  <= '0;
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					step_q <= step_q + 1'b1;
					if (step_q == STEP_W'(SUM_W - 1))
						state_q <= S_SEG;
				end
				S_SEG: begin
					state_q <= S_PCT;
				end
				S_PCT: begin
					// hold here until the output register can take the result
					if (out_free)
						state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// datapath registers, no reset needed
	always_ff @(posedge clk) begin
		if (in_fire)
			samp_q <= sample_ch.sample_mv;
		if (state_q == S_MUL)
			scaled_q <= mul_full[bvg_pkg::GAIN_FRAC +: bvg_pkg::MV_W];
		if (state_q == S_WR)
			acc_q <= '0;
		else if (state_q == S_SUM && rd_vld_q)
			acc_q <= acc_q + SUM_W'(rd_data);
		if (state_q == S_SUM) begin
			quo_q <= acc_q;
			rem_q <= '0;
		end else if (state_q == S_DIV) begin
			quo_q <= {quo_q[SUM_W-2:0], rem_ge};
			rem_q <= rem_ge ? CNT_W'(rem_shift - (CNT_W + 1)'(cnt_q))
				: rem_shift[CNT_W-1:0];
		end
		if (state_q == S_SEG) begin
			avg_q      <= quo_q[bvg_pkg::MV_W-1:0];
			prod_q     <= bvg_pkg::PROD_W'(seg_diff) * bvg_pkg::PROD_W'(seg.span);
			base_q     <= seg.base;
			wide_q     <= seg.wide;
			clamp_hi_q <= (quo_q[bvg_pkg::MV_W-1:0] >= bvg_pkg::FULL_MV);
			clamp_lo_q <= (quo_q[bvg_pkg::MV_W-1:0] <= bvg_pkg::EMPTY_MV);
		end
		if (state_q == S_PCT && out_free) begin
			out_avg_q <= avg_q;
			out_pct_q <= pct;
			out_low_q <= (avg_q < low_mv_q) || (pct < low_pct_q);
		end
	end

	// the mean never divides by zero
	a_cnt_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DIV |-> cnt_q != '0)
		else $error("fill count zero during division");

	// a sample transaction starts the scaling step
	a_fire_to_mul: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> state_q == S_MUL)
		else $error("sequencer missed a sample transaction");

	// the ring only becomes full when the slot wraps to zero
	a_full_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(full_q) |-> slot_q == '0)
		else $error("ring full without wrap");

	// percentages stay on the curve
	a_pct_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q |-> out_pct_q <= bvg_pkg::PCT_FULL)
		else $error("charge percent above full");

	// sweep never reads past the fill count
	a_sweep_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SUM |-> iss_q <= cnt_q)
		else $error("ring read beyond fill count");

endmodule

FILE: tb/tb.sv
// self-checking testbench for the battery voltage gauge
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CLK_PERIOD     = 10;
	localparam int RESET_CYCLES   = 8;
	localparam int RING_DEPTH     = 8;
	// no transaction for this long on either channel means the block hung
	localparam int WATCHDOG_LIMIT = 3000;
	// quiet cycles after the last result
	localparam int END_SETTLE     = 64;
	localparam int IDLE_PCT       = 17;

	localparam int SMP_W = bvg_pkg::SAMPLE_W;
	localparam int MV_W  = bvg_pkg::MV_W;
	localparam int PCT_W = bvg_pkg::PCT_W;

	// index past the register list, writes to it must be dropped
	localparam logic [bvg_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

	// lipo discharge curve, highest segment first
	localparam int CURVE_SEGS = 11;
	localparam int unsigned CURVE_LO [CURVE_SEGS] =
		'{4100, 4000, 3900, 3800, 3700, 3600, 3500, 3400, 3300, 3200, 3000};
	localparam int unsigned CURVE_BASE [CURVE_SEGS] =
		'{95, 85, 75, 60, 40, 25, 15, 8, 4, 1, 0};
	localparam int unsigned CURVE_SPAN [CURVE_SEGS] =
		'{5, 10, 10, 15, 20, 15, 10, 7, 4, 3, 1};
	localparam int unsigned CURVE_WIDTH [CURVE_SEGS] =
		'{100, 100, 100, 100, 100, 100, 100, 100, 100, 100, 200};
	localparam int unsigned CURVE_TOP_MV    = 4200;
	localparam int unsigned CURVE_BOTTOM_MV = 3000;

	// directed samples at the reset gain of 3.0: field extremes, then a full ring
	// pinned at 4200 mv, a full ring pinned at 3000 mv, then values near the ends and between
	localparam logic [SMP_W-1:0] DIRECTED [25] = '{
		12'd0, 12'd4095, 12'd0, 12'd4095,
		12'd1400, 12'd1400, 12'd1400, 12'd1400, 12'd1400, 12'd1400, 12'd1400, 12'd1400,
		12'd1000, 12'd1000, 12'd1000, 12'd1000, 12'd1000, 12'd1000, 12'd1000, 12'd1000,
		12'd1399, 12'd1001, 12'd1367, 12'd1234, 12'd1100
	};

	typedef struct packed {
		logic [MV_W-1:0]  average_mv;
		logic [PCT_W-1:0] charge_percent;
		logic             battery_low;
	} gauge_reading_t;

	// tracks the gauge state and holds the readings still owed by the block
	class charge_tracker;
		logic [15:0] gain;
		logic [15:0] low_mv;
		logic [6:0]  low_pct;
		logic [MV_W-1:0] ring [RING_DEPTH];
		int unsigned slot;
		bit wrapped;
		gauge_reading_t owed_readings [$];
		int unsigned errors;
		int unsigned checked;
		int unsigned full_seen;
		int unsigned empty_seen;
		int unsigned low_seen;

		function new();
			gain    = bvg_pkg::GAIN_RESET;
			low_mv  = bvg_pkg::LOW_VOLTAGE_RESET;
			low_pct = bvg_pkg::LOW_PERCENT_RESET;
			slot    = 0;
			wrapped = 1'b0;
			errors  = 0;
			checked = 0;
			full_seen  = 0;
			empty_seen = 0;
			low_seen   = 0;
		endfunction

		function void set_register(logic [bvg_pkg::CFG_IDX_W-1:0] idx,
				logic [bvg_pkg::CFG_DATA_W-1:0] data);
			case (idx)
				bvg_pkg::REG_DIVIDER_GAIN:   gain    = data[15:0];
				bvg_pkg::REG_LOW_VOLTAGE_MV: low_mv  = data[15:0];
				bvg_pkg::REG_LOW_PERCENT:    low_pct = data[6:0];
				default: ;
			endcase
		endfunction

		function int unsigned curve_percent(int unsigned mv);
			if (mv >= CURVE_TOP_MV)
				return 100;
			if (mv <= CURVE_BOTTOM_MV)
				return 0;
			for (int i = 0; i < CURVE_SEGS; i++) begin
				if (mv >= CURVE_LO[i])
					return CURVE_BASE[i] + (mv - CURVE_LO[i]) * CURVE_SPAN[i] / CURVE_WIDTH[i];
			end
			return 0;
		endfunction

		// scale, push into the ring, average the written entries, map to charge
		function void take_sample(logic [SMP_W-1:0] smp);
			logic [27:0] prod;
			int unsigned count;
			int unsigned sum;
			int unsigned avg;
			int unsigned pct;
			gauge_reading_t r;
			prod = 28'(smp) * 28'(gain);
			ring[slot] = prod[27:12];
			slot++;
			if (slot == RING_DEPTH) begin
				slot = 0;
				wrapped = 1'b1;
			end
			count = wrapped ? RING_DEPTH : slot;
			sum = 0;
			for (int i = 0; i < count; i++)
				sum += ring[i];
			avg = sum / count;
			pct = curve_percent(avg);
			r.average_mv     = avg[MV_W-1:0];
			r.charge_percent = pct[PCT_W-1:0];
			r.battery_low    = (avg < low_mv) || (pct < low_pct);
			owed_readings.push_back(r);
		endfunction

		function void match_reading(gauge_reading_t got);
			gauge_reading_t want;
			if (owed_readings.size() == 0) begin
				$display("%0t: unexpected result avg=%0d pct=%0d low=%0d", $time,
					got.average_mv, got.charge_percent, got.battery_low);
				errors++;
				return;
			end
			want = owed_readings.pop_front();
			checked++;
			if (want.charge_percent == 100)
				full_seen++;
			if (want.charge_percent == 0)
				empty_seen++;
			if (want.battery_low)
				low_seen++;
			if (got.average_mv !== want.average_mv) begin
				$display("%0t: average_mv expected %0d actual %0d", $time,
					want.average_mv, got.average_mv);
				errors++;
			end
			if (got.charge_percent !== want.charge_percent) begin
				$display("%0t: charge_percent expected %0d actual %0d", $time,
					want.charge_percent, got.charge_percent);
				errors++;
			end
			if (got.battery_low !== want.battery_low) begin
				$display("%0t: battery_low expected %0d actual %0d", $time,
					want.battery_low, got.battery_low);
				errors++;
			end
		endfunction

		function int unsigned owed();
			return owed_readings.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_wr_en;
	logic [bvg_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [bvg_pkg::CFG_DATA_W-1:0] cfg_wdata;

	bvg_sample_if sample_ch ();
	bvg_result_if result_ch ();

	charge_tracker tracker = new();

	// set during the stretch where neither side holds back
	bit no_idle = 1'b0;
	int unsigned samples_sent = 0;
	int unsigned settings_used = 0;
	int unsigned quiet_cycles = 0;

	battery_voltage_gauge #(
		.SAMPLES(RING_DEPTH)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.sample_ch (sample_ch),
		.result_ch (result_ch)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// one register write per edge; enable is lowered by the caller after the batch
	task automatic write_reg(input logic [bvg_pkg::CFG_IDX_W-1:0] idx,
			input logic [bvg_pkg::CFG_DATA_W-1:0] data);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		tracker.set_register(idx, data);
	endtask

	// full register set plus a stray write past the list, only while idle
	task automatic load_settings(input logic [15:0] gain, input logic [15:0] low_mv,
			input logic [15:0] pct_raw);
		write_reg(bvg_pkg::REG_DIVIDER_GAIN, gain);
		write_reg(bvg_pkg::REG_LOW_VOLTAGE_MV, low_mv);
		write_reg(bvg_pkg::REG_LOW_PERCENT, pct_raw);
		write_reg(REG_UNUSED, 16'($urandom));
		cfg_wr_en <= 1'b0;
		@(posedge clk);
		settings_used++;
	endtask

	// one sample transaction, with an occasional gap of random length first
	task automatic send_sample(input logic [SMP_W-1:0] smp);
		int gap;
		if (!no_idle && $urandom_range(99) < IDLE_PCT) begin
			gap = $urandom_range(48, 1);
			sample_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		sample_ch.valid     <= 1'b1;
		sample_ch.sample_mv <= smp;
		@(posedge clk);
		while (!sample_ch.ready)
			@(posedge clk);
		tracker.take_sample(smp);
		samples_sent++;
	endtask

	task automatic drain();
		while (tracker.owed() != 0)
			@(posedge clk);
	endtask

	// one register setting followed by a run of random samples
	task automatic run_phase(input logic [15:0] gain, input logic [15:0] low_mv,
			input logic [15:0] pct_raw, input int items, input bit calm);
		int level;
		int roll;
		int unsigned smp;
		load_settings(gain, low_mv, pct_raw);
		no_idle = calm;
		level = $urandom_range(4300, 2900);
		repeat (items) begin
			// a slowly drifting battery level keeps the mean sweeping the curve
			level += int'($urandom_range(80)) - 40;
			if ($urandom_range(99) < 5)
				level = $urandom_range(4300, 2900);
			if (level < 2900)
				level = 2900;
			if (level > 4300)
				level = 4300;
			roll = $urandom_range(99);
			if (gain != 0 && roll < 75) begin
				smp = (unsigned'(level) * 4096) / gain;
				if (smp > 4095)
					smp = 4095;
			end else if (roll < 92) begin
				smp = $urandom_range(4095);
			end else begin
				smp = roll[0] ? 4095 : 0;
			end
			send_sample(smp[SMP_W-1:0]);
		end
		sample_ch.valid <= 1'b0;
		drain();
		no_idle = 1'b0;
	endtask

	// result side: check each transaction, then pick the next ready
	initial begin
		gauge_reading_t got;
		result_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (result_ch.valid && result_ch.ready) begin
				got.average_mv     = result_ch.average_mv;
				got.charge_percent = result_ch.charge_percent;
				got.battery_low    = result_ch.battery_low;
				tracker.match_reading(got);
			end
			result_ch.ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
		end
	end

	// watchdog on cycles without any transaction
	always @(posedge clk) begin
		if ((sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles == WATCHDOG_LIMIT) begin
			$display("%0t: no transaction for %0d cycles, %0d results outstanding",
				$time, WATCHDOG_LIMIT, tracker.owed());
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin
		// every block input known from time zero
		arst_n              <= 1'b0;
		cfg_wr_en           <= 1'b0;
		cfg_index           <= bvg_pkg::REG_DIVIDER_GAIN;
		cfg_wdata           <= '0;
		sample_ch.valid     <= 1'b0;
		sample_ch.sample_mv <= '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed pass on the reset register values
		foreach (DIRECTED[i])
			send_sample(DIRECTED[i]);
		sample_ch.valid <= 1'b0;
		drain();

		// nominal divider written explicitly
		run_phase(16'd12288, 16'd3300, 16'd10, 40, 1'b0);
		// random nominal-ish setting
		run_phase(16'($urandom_range(16384, 8192)), 16'($urandom_range(4200, 3000)),
			16'($urandom_range(100)), 50, 1'b0);
		// zero gain with both thresholds at zero, flag must stay clear
		run_phase(16'd0, 16'd0, 16'd0, 15, 1'b0);
		// zero gain with normal thresholds, flag always set
		run_phase(16'd0, 16'd3300, 16'd10, 10, 1'b0);
		// every register at its top, percent threshold above 100
		run_phase(16'hFFFF, 16'hFFFF, 16'hFFFF, 25, 1'b0);
		// smallest gain, thresholds at zero
		run_phase(16'd1, 16'd0, 16'd0, 20, 1'b0);
		// percent threshold just above 100, upper data bits masked away
		run_phase(16'd12288, 16'd3500, 16'hFF80 | 16'd101, 25, 1'b0);
		// long stretch with no idling on either side
		run_phase(16'd10923, 16'd3400, 16'd20, 100, 1'b1);
		// anything the register widths allow
		run_phase(16'($urandom_range(65535, 1)), 16'($urandom), 16'($urandom), 40, 1'b0);
		run_phase(16'd14000, 16'd3700, 16'd50, 50, 1'b0);

		repeat (END_SETTLE) @(posedge clk);

		$display("covered %0d samples across %0d register settings, %0d results checked",
			samples_sent, settings_used, tracker.checked);
		$display("results at full charge %0d, at empty %0d, flagged low %0d",
			tracker.full_seen, tracker.empty_seen, tracker.low_seen);
		if (tracker.errors == 0 && tracker.owed() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
